/* rtl/ssw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_pkg: shared types and constants of the sequence window bitmap
// Mode codes, command kinds, the command word passed from front to back,
// and the widths of the stream words.
// ----------------------------------------------------------------------------
package ssw_pkg;

    localparam int WINDOW_BITS_DEF = 64;
    localparam int WINDOW_BITS_MAX = 1024;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int SEQ_W   = 16;
    localparam int COUNT_W = 7;
    // Shift amount / bit position, holds 0..WINDOW_BITS_MAX
    localparam int AMT_W   = $clog2(WINDOW_BITS_MAX + 1);

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    localparam int QUEUE_DEPTH = 2;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_RECV  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Command kinds
    localparam logic [2:0] KIND_NOP   = 3'd0;
    localparam logic [2:0] KIND_OLD   = 3'd1;
    localparam logic [2:0] KIND_JUMP  = 3'd2;
    localparam logic [2:0] KIND_ADV   = 3'd3;
    localparam logic [2:0] KIND_QUERY = 3'd4;
    localparam logic [2:0] KIND_CLEAR = 3'd5;

    typedef struct packed {
        logic [2:0]       kind;
        logic             mark;   // receive: set a bit; query: distance in window
        logic [AMT_W-1:0] amt;    // shift amount, bit to mark or bit to read
    } cmd_t;

    localparam int CMD_W = $bits(cmd_t);

endpackage

/* rtl/ssw_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_front: classify incoming words
// Turns mode, sequence difference and query numbers into a command for the
// window engine: old packet, far jump, advance, query, clear or no-op.
// ----------------------------------------------------------------------------
module ssw_front #(
    parameter int WINDOW_BITS = ssw_pkg::WINDOW_BITS_DEF
) (
    input  logic [ssw_pkg::MODE_W-1:0] mode,
    input  logic [ssw_pkg::SEQ_W-1:0]  seq_diff,
    input  logic                       pkt_mark,
    input  logic [ssw_pkg::SEQ_W-1:0]  newest_seq,
    input  logic [ssw_pkg::SEQ_W-1:0]  asked_seq,
    output ssw_pkg::cmd_t              cmd
);

    localparam logic signed [ssw_pkg::SEQ_W:0] W_POS = (ssw_pkg::SEQ_W+1)'(WINDOW_BITS);
    localparam logic signed [ssw_pkg::SEQ_W:0] W_NEG = -W_POS;

    logic signed [ssw_pkg::SEQ_W:0]   diff_ext;
    logic signed [ssw_pkg::SEQ_W:0]   diff_neg;
    logic signed [ssw_pkg::SEQ_W:0]   gap_ext;
    logic        [ssw_pkg::SEQ_W-1:0] gap;

    assign diff_ext = {seq_diff[ssw_pkg::SEQ_W-1], seq_diff};
    assign diff_neg = -diff_ext;
    assign gap      = newest_seq - asked_seq;
    assign gap_ext  = {gap[ssw_pkg::SEQ_W-1], gap};

    always_comb begin
        cmd.kind = ssw_pkg::KIND_NOP;
        cmd.mark = 1'b0;
        cmd.amt  = '0;
        case (mode)
            ssw_pkg::MODE_RECV: begin
                cmd.mark = pkt_mark;
                if (diff_ext < 0 && diff_ext >= W_NEG) begin
                    cmd.kind = ssw_pkg::KIND_OLD;
                    cmd.amt  = diff_neg[ssw_pkg::AMT_W-1:0];
                end else if (diff_ext > W_POS || diff_ext < W_NEG) begin
                    cmd.kind = ssw_pkg::KIND_JUMP;
                end else begin
                    cmd.kind = ssw_pkg::KIND_ADV;
                    cmd.amt  = diff_ext[ssw_pkg::AMT_W-1:0];
                end
            end
            ssw_pkg::MODE_QUERY: begin
                cmd.kind = ssw_pkg::KIND_QUERY;
                cmd.mark = (gap_ext >= 0) && (gap_ext < W_POS);
                cmd.amt  = gap_ext[ssw_pkg::AMT_W-1:0];
            end
            ssw_pkg::MODE_CLEAR: begin
                cmd.kind = ssw_pkg::KIND_CLEAR;
            end
            default: begin
                cmd.kind = ssw_pkg::KIND_NOP;
            end
        endcase
    end

endmodule

/* rtl/ssw_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_cmd_fifo: command queue between front and back
// A small register FIFO; full and empty are flagged from an entry count so
// that push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module ssw_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  ssw_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ssw_pkg::cmd_t pop_cmd
);

    localparam int PTR_W = $clog2(ssw_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ssw_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(ssw_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_C  = PTR_W'(ssw_pkg::QUEUE_DEPTH - 1);

    ssw_pkg::cmd_t    entry_reg [ssw_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != DEPTH_C);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/ssw_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_back: window engine and result stage
// Executes one command per cycle against the window register unless the output
// stalls, then counts the set bits of the updated window as the result moves to the output.
// ----------------------------------------------------------------------------
module ssw_back #(
    parameter int WINDOW_BITS = ssw_pkg::WINDOW_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  ssw_pkg::cmd_t                 cmd,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ssw_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int IDX_W   = (WINDOW_BITS > 1) ? $clog2(WINDOW_BITS) : 1;
    localparam int SUM_W   = $clog2(WINDOW_BITS + 1);
    localparam int GROUPS  = (WINDOW_BITS + 7) / 8;
    localparam int PAD_W   = GROUPS * 8;
    localparam logic [ssw_pkg::AMT_W-1:0] W_AMT = ssw_pkg::AMT_W'(WINDOW_BITS);

    logic [WINDOW_BITS-1:0] window_reg, window_next;
    logic                   e_valid_reg;
    logic                   e_new_reg, e_new_next;
    logic                   e_seen_reg, e_seen_next;
    logic                   m_valid_reg;
    logic                   m_new_reg, m_seen_reg;
    logic [ssw_pkg::COUNT_W-1:0] m_count_reg;
    logic                   e_move, exec;

    logic [PAD_W-1:0]       window_pad;
    logic [3:0]             group_sum [GROUPS];
    logic [SUM_W-1:0]       pop_sum;

    assign e_move    = e_valid_reg && (!m_valid_reg || m_tready);
    assign cmd_ready = !e_valid_reg || e_move;
    assign exec      = cmd_valid && cmd_ready;

    always_comb begin
        window_next = window_reg;
        e_new_next  = 1'b0;
        e_seen_next = 1'b0;
        case (cmd.kind)
            ssw_pkg::KIND_OLD: begin
                // bit WINDOW_BITS itself lies outside the window: drop it
                if (cmd.mark && cmd.amt < W_AMT) begin
                    window_next[cmd.amt[IDX_W-1:0]] = 1'b1;
                end
            end
            ssw_pkg::KIND_JUMP: begin
                window_next    = '0;
                window_next[0] = cmd.mark;
                e_new_next     = 1'b1;
            end
            ssw_pkg::KIND_ADV: begin
                window_next = window_reg << cmd.amt;
                if (cmd.mark) begin
                    window_next[0] = 1'b1;
                end
                e_new_next = 1'b1;
            end
            ssw_pkg::KIND_QUERY: begin
                e_seen_next = cmd.mark && window_reg[cmd.amt[IDX_W-1:0]];
            end
            ssw_pkg::KIND_CLEAR: begin
                window_next = '0;
            end
            default: begin
                window_next = window_reg;
            end
        endcase
    end

    // Popcount: byte sums, then a sum over the bytes
    assign window_pad = PAD_W'(window_reg);

    for (genvar g = 0; g < GROUPS; g++) begin : g_byte
        always_comb begin
            group_sum[g] = '0;
            for (int b = 0; b < 8; b++) begin
                group_sum[g] = group_sum[g] + 4'(window_pad[g*8 + b]);
            end
        end
    end

    always_comb begin
        pop_sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            pop_sum = pop_sum + SUM_W'(group_sum[g]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            e_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (exec) begin
                window_reg <= window_next;
            end
            if (exec) begin
                e_valid_reg <= 1'b1;
            end else if (e_move) begin
                e_valid_reg <= 1'b0;
            end
            if (e_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            e_new_reg  <= e_new_next;
            e_seen_reg <= e_seen_next;
        end
        // window_reg still holds this word's update while it moves out
        if (e_move) begin
            m_new_reg   <= e_new_reg;
            m_seen_reg  <= e_seen_reg;
            m_count_reg <= ssw_pkg::COUNT_W'(pop_sum);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = ssw_pkg::M_TDATA_W'({m_count_reg, m_seen_reg, m_new_reg});

endmodule

/* rtl/seqno_sliding_window_bitmap.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqno_sliding_window_bitmap: sliding window of received sequence numbers
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tuser mode, s_tdata packet/query fields
//   m_       out  m_tvalid/m_tready  m_tdata is_new, bit_seen, received_count
//
// One word per cycle unless the output stalls; each word yields one result
// through the command queue, engine register and output register. At most one
// command per cycle updates the window; the popcount feeds the output register.
// Reset (aresetn low, synchronous) empties the window and all queues.
// A stalled output holds the back; the two-entry command queue keeps the
// front accepting until it fills.
// ----------------------------------------------------------------------------
module seqno_sliding_window_bitmap #(
    parameter int WINDOW_BITS = ssw_pkg::WINDOW_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] mode
    input  logic [ssw_pkg::MODE_W-1:0]    s_tuser,
    // [15:0] seq_diff, [16] pkt_mark, [32:17] newest_seq, [48:33] asked_seq
    input  logic [ssw_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] is_new, [1] bit_seen, [8:2] received_count
    output logic [ssw_pkg::M_TDATA_W-1:0] m_tdata
);

    ssw_pkg::cmd_t front_cmd;
    ssw_pkg::cmd_t back_cmd;
    logic          back_valid, back_ready;

    ssw_front #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_front (
        .mode       (s_tuser),
        .seq_diff   (s_tdata[15:0]),
        .pkt_mark   (s_tdata[16]),
        .newest_seq (s_tdata[32:17]),
        .asked_seq  (s_tdata[48:33]),
        .cmd        (front_cmd)
    );

    ssw_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid),
        .push_ready (s_tready),
        .push_cmd   (front_cmd),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_cmd    (back_cmd)
    );

    ssw_back #(
        .WINDOW_BITS(WINDOW_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // A word is either new or a query hit, never both
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("is_new and bit_seen both set");

    // Count never exceeds the window size
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (WINDOW_BITS > 127) || (int'(m_tdata[8:2]) <= WINDOW_BITS))
        else $error("received_count above window size");

    // Nothing is presented right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
